@@ rtl/sod_pkg.sv @@
// shared types and constants for the sequencer ordered delivery block
package sod_pkg;

  // result kinds
  typedef enum logic [1:0] {
    KIND_DELIVER = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_DROP    = 2'd2,
    KIND_NO_WAIT = 2'd3
  } kind_e;

  // input opcodes
  localparam logic OP_DATA = 1'b0;
  localparam logic OP_ACK  = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_NODE_ID    = 2'd0;
  localparam logic [1:0] CFG_NODE_COUNT = 2'd1;

  // node id of the sequencer
  localparam logic [2:0] SEQUENCER_ID = 3'd0;

  typedef struct packed {
    logic        opcode;
    logic [2:0]  sender_id;
    logic [31:0] seq_number;
    logic [31:0] ack_number;
  } in_t;

  typedef struct packed {
    kind_e       kind;
    logic [2:0]  out_sender;
    logic [31:0] out_seq;
    logic [31:0] order_number;
    logic        last;
  } out_t;

  // one ordered queue entry
  typedef struct packed {
    logic [2:0]  sender;
    logic [31:0] seq;
    logic [7:0]  mask;
  } entry_t;

  // control broadcast to every queue cell
  typedef struct packed {
    logic        sweep;
    logic        strict;
    logic [7:0]  clr;
    logic        shift;
    logic [31:0] ack;
    logic [31:0] base;
  } cell_ctl_t;

endpackage

@@ rtl/sod_ram.sv @@
// generic single write port ram with registered read
module sod_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

@@ rtl/sod_cell.sv @@
// one ordered queue cell: holds an entry, clears pending bits, shifts toward the head
module sod_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic               clk_i,
  input  sod_pkg::cell_ctl_t ctl_i,
  input  logic               wr_en_i,
  input  sod_pkg::entry_t    wr_entry_i,
  input  sod_pkg::entry_t    nb_entry_i,
  output sod_pkg::entry_t    entry_o
);
  import sod_pkg::*;

  entry_t      entry_q, entry_d;
  logic [31:0] pos;
  logic        hit;

  // absolute position of this cell against the ack
  assign pos = ctl_i.base + 32'(CELL_IDX);
  assign hit = ctl_i.strict ? (pos < ctl_i.ack) : (pos <= ctl_i.ack);

  // next entry
  always_comb begin
    entry_d = entry_q;
    if (wr_en_i) begin
      entry_d = wr_entry_i;
    end else if (ctl_i.shift) begin
      entry_d = nb_entry_i;
    end else if (ctl_i.sweep && hit) begin
      entry_d.mask = entry_q.mask & ~ctl_i.clr;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
endmodule

@@ rtl/sequencer_ordered_delivery_top.sv @@
// top level: one node of a fixed-sequencer total-order broadcast
// One item is taken at a time. A data message passes through the accept state, a sweep
// state, a head check state that stays while the head entry can be delivered (each delivery
// pops the head cell of the queue chain and shifts every cell one place toward the head), a
// tail state for the closing ack or drop and a closing state. On the sequencer a message
// from another node gets its append after the deliveries. An ack item on a non sequencer
// node reads the waiting-fifo ram and appends, or goes straight to the closing state when
// nothing waits; on the sequencer it is ignored. A result is held one slot back so that the
// final one can carry last, and any stall on the output holds the block back. Node 0 is the
// sequencer; node_id and node_count must be written only while the block is idle, which the
// block itself does not enforce.
module sequencer_ordered_delivery_top #(
  parameter int MAX_SENDERS = 8,
  parameter int QUEUE_DEPTH = 16,
  parameter int WAIT_DEPTH  = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sod_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output sod_pkg::out_t  out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [1:0]     cfg_index_i,
  input  logic [3:0]     cfg_data_i
);
  import sod_pkg::*;

  localparam int QFW = $clog2(QUEUE_DEPTH + 1);
  localparam int QIW = $clog2(QUEUE_DEPTH);
  localparam int SW  = $clog2(MAX_SENDERS);
  localparam int HW  = $clog2(WAIT_DEPTH);
  localparam int FW  = $clog2(WAIT_DEPTH + 1);
  localparam int WAW = $clog2(MAX_SENDERS * WAIT_DEPTH);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SWEEP  = 3'd1;
  localparam logic [2:0] S_DELIV  = 3'd2;
  localparam logic [2:0] S_SEQAPP = 3'd3;
  localparam logic [2:0] S_TAIL   = 3'd4;
  localparam logic [2:0] S_WREAD  = 3'd5;
  localparam logic [2:0] S_FLUSH  = 3'd6;

  logic [2:0]     state_q, state_d;
  logic [2:0]     node_id_q;
  logic [3:0]     node_count_q;
  logic [QFW-1:0] q_fill_q, q_fill_d;
  logic [31:0]    dt_q, dt_d;
  logic [31:0]    oc_q, oc_d;
  logic [HW-1:0]  w_head_q [MAX_SENDERS];
  logic [FW-1:0]  w_fill_q [MAX_SENDERS];
  logic [2:0]     snd_q, snd_d;
  logic [31:0]    seq_q, seq_d;
  logic [31:0]    ack_q, ack_d;
  logic           strict_q, strict_d;
  logic           seqapp_q, seqapp_d;
  logic           tail_v_q, tail_v_d;
  out_t           tail_q, tail_d;
  logic           hold_v_q, hold_v_d;
  out_t           hold_q, hold_d;
  logic           out_valid_q, out_valid_d;
  out_t           out_q, out_d;

  entry_t         cell_q [QUEUE_DEPTH];
  cell_ctl_t      ctl;
  logic           app_en;
  entry_t         app_entry;
  logic [7:0]     full_mask;

  logic           emit_req, emit_ok, slot_free;
  out_t           emit_res;

  logic           ram_we, ram_re;
  logic [WAW-1:0] ram_waddr, ram_raddr;
  logic [31:0]    ram_rdata;
  logic           w_push, w_pop;

  logic [31:0]    snd_ext;
  logic [SW-1:0]  sidx;
  logic           s_ok;
  logic [HW-1:0]  cur_head, head_inc;
  logic [FW-1:0]  cur_fill;
  logic [FW:0]    slot_sum;
  logic [HW-1:0]  slot;

  // configuration port
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q    <= 3'd0;
      node_count_q <= 4'd2;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_NODE_ID:    node_id_q    <= cfg_data_i[2:0];
        CFG_NODE_COUNT: node_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign full_mask = (node_count_q >= 4'd8) ? 8'hff : 8'((9'd1 << node_count_q) - 9'd1);

  // waiting fifo addressing for the incoming sender
  assign snd_ext  = 32'(in_data_i.sender_id);
  assign sidx     = snd_ext[SW-1:0];
  assign s_ok     = snd_ext < 32'(MAX_SENDERS);
  assign cur_head = w_head_q[sidx];
  assign cur_fill = w_fill_q[sidx];
  assign slot_sum = (FW+1)'(cur_head) + (FW+1)'(cur_fill);
  assign slot     = (slot_sum >= (FW+1)'(WAIT_DEPTH)) ? HW'(slot_sum - (FW+1)'(WAIT_DEPTH))
                                                       : HW'(slot_sum);
  assign head_inc = (32'(cur_head) + 32'd1 == 32'(WAIT_DEPTH)) ? '0 : HW'(cur_head + 1'b1);
  assign ram_waddr = WAW'(sidx) * WAW'(WAIT_DEPTH) + WAW'(slot);
  assign ram_raddr = WAW'(sidx) * WAW'(WAIT_DEPTH) + WAW'(cur_head);

  sod_ram #(
    .WIDTH(32),
    .DEPTH(MAX_SENDERS * WAIT_DEPTH)
  ) u_wait_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(in_data_i.seq_number),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // ordered queue as a chain of cells, cell 0 is the head
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t nb;
    if (i == QUEUE_DEPTH - 1) begin : g_end
      assign nb = cell_q[i];
    end else begin : g_mid
      assign nb = cell_q[i+1];
    end
    sod_cell #(.CELL_IDX(i)) u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .wr_en_i   (app_en && (q_fill_q[QIW-1:0] == QIW'(i))),
      .wr_entry_i(app_entry),
      .nb_entry_i(nb),
      .entry_o   (cell_q[i])
    );
  end

  assign slot_free  = !out_valid_q || out_ready_i;
  assign emit_ok    = !hold_v_q || slot_free;
  assign in_ready_o = (state_q == S_IDLE);

  // sequencer of one item
  always_comb begin
    state_d   = state_q;
    q_fill_d  = q_fill_q;
    dt_d      = dt_q;
    oc_d      = oc_q;
    snd_d     = snd_q;
    seq_d     = seq_q;
    ack_d     = ack_q;
    strict_d  = strict_q;
    seqapp_d  = seqapp_q;
    tail_v_d  = tail_v_q;
    tail_d    = tail_q;
    app_en    = 1'b0;
    app_entry = '{sender: in_data_i.sender_id, seq: in_data_i.seq_number, mask: full_mask};
    ctl       = '{sweep: 1'b0, strict: strict_q, clr: 8'(8'd1 << snd_q), shift: 1'b0,
                  ack: ack_q, base: dt_q};
    emit_req  = 1'b0;
    emit_res  = '{kind: KIND_DROP, out_sender: in_data_i.sender_id,
                  out_seq: in_data_i.seq_number, order_number: 32'd0, last: 1'b0};
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    w_push    = 1'b0;
    w_pop     = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          snd_d    = in_data_i.sender_id;
          seq_d    = in_data_i.seq_number;
          ack_d    = in_data_i.ack_number;
          strict_d = 1'b0;
          seqapp_d = 1'b0;
          tail_v_d = 1'b0;
          if (in_data_i.opcode == OP_DATA) begin
            state_d = S_SWEEP;
            if (node_id_q == SEQUENCER_ID) begin
              if (in_data_i.sender_id == SEQUENCER_ID) begin
                if (q_fill_q < QFW'(QUEUE_DEPTH)) begin
                  app_en   = 1'b1;
                  q_fill_d = q_fill_q + 1'b1;
                  oc_d     = oc_q + 32'd1;
                  tail_v_d = 1'b1;
                  tail_d   = '{kind: KIND_ACK, out_sender: in_data_i.sender_id,
                               out_seq: in_data_i.seq_number, order_number: oc_q + 32'd1,
                               last: 1'b0};
                end else begin
                  emit_req = 1'b1;
                end
              end else begin
                strict_d = 1'b1;
                seqapp_d = 1'b1;
              end
            end else if (s_ok && (cur_fill < FW'(WAIT_DEPTH))) begin
              ram_we = 1'b1;
              w_push = 1'b1;
            end else begin
              emit_req = 1'b1;
            end
          end else if (node_id_q != SEQUENCER_ID) begin
            oc_d = in_data_i.ack_number;
            if (!s_ok || (cur_fill == '0)) begin
              emit_req      = 1'b1;
              emit_res.kind = KIND_NO_WAIT;
              state_d       = S_FLUSH;
            end else begin
              ram_re  = 1'b1;
              w_pop   = 1'b1;
              state_d = S_WREAD;
            end
          end
        end
      end
      S_SWEEP: begin
        ctl.sweep = 1'b1;
        state_d   = S_DELIV;
      end
      S_DELIV: begin
        if ((q_fill_q != '0) && (cell_q[0].mask == 8'd0)) begin
          emit_req = 1'b1;
          emit_res = '{kind: KIND_DELIVER, out_sender: cell_q[0].sender,
                       out_seq: cell_q[0].seq, order_number: 32'd0, last: 1'b0};
          if (emit_ok) begin
            ctl.shift = 1'b1;
            q_fill_d  = q_fill_q - 1'b1;
            dt_d      = dt_q + 32'd1;
          end
        end else begin
          state_d = seqapp_q ? S_SEQAPP : S_TAIL;
        end
      end
      S_SEQAPP: begin
        app_entry = '{sender: snd_q, seq: seq_q, mask: full_mask};
        tail_v_d  = 1'b1;
        if (q_fill_q < QFW'(QUEUE_DEPTH)) begin
          app_en   = 1'b1;
          q_fill_d = q_fill_q + 1'b1;
          oc_d     = oc_q + 32'd1;
          tail_d   = '{kind: KIND_ACK, out_sender: snd_q, out_seq: seq_q,
                       order_number: oc_q + 32'd1, last: 1'b0};
        end else begin
          tail_d   = '{kind: KIND_DROP, out_sender: snd_q, out_seq: seq_q,
                       order_number: 32'd0, last: 1'b0};
        end
        state_d = S_TAIL;
      end
      S_TAIL: begin
        if (tail_v_q) begin
          emit_req = 1'b1;
          emit_res = tail_q;
          if (emit_ok) begin
            tail_v_d = 1'b0;
            state_d  = S_FLUSH;
          end
        end else begin
          state_d = S_FLUSH;
        end
      end
      S_WREAD: begin
        app_entry = '{sender: snd_q, seq: ram_rdata, mask: full_mask};
        if (q_fill_q < QFW'(QUEUE_DEPTH)) begin
          app_en   = 1'b1;
          q_fill_d = q_fill_q + 1'b1;
        end else begin
          emit_req = 1'b1;
          emit_res = '{kind: KIND_DROP, out_sender: snd_q, out_seq: ram_rdata,
                       order_number: 32'd0, last: 1'b0};
        end
        state_d = S_FLUSH;
      end
      S_FLUSH: begin
        if (!hold_v_q || slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // one result held back so the final one can be marked last
  always_comb begin
    hold_v_d    = hold_v_q;
    hold_d      = hold_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (emit_req && emit_ok) begin
      if (hold_v_q) begin
        out_d       = hold_q;
        out_d.last  = 1'b0;
        out_valid_d = 1'b1;
      end
      hold_d   = emit_res;
      hold_v_d = 1'b1;
    end else if ((state_q == S_FLUSH) && hold_v_q && slot_free) begin
      out_d       = hold_q;
      out_d.last  = 1'b1;
      out_valid_d = 1'b1;
      hold_v_d    = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      q_fill_q    <= '0;
      dt_q        <= 32'd0;
      oc_q        <= 32'd0;
      tail_v_q    <= 1'b0;
      hold_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
      seqapp_q    <= 1'b0;
      strict_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      q_fill_q    <= q_fill_d;
      dt_q        <= dt_d;
      oc_q        <= oc_d;
      tail_v_q    <= tail_v_d;
      hold_v_q    <= hold_v_d;
      out_valid_q <= out_valid_d;
      seqapp_q    <= seqapp_d;
      strict_q    <= strict_d;
    end
  end

  // per-sender waiting fifo pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < MAX_SENDERS; s++) begin
        w_head_q[s] <= '0;
        w_fill_q[s] <= '0;
      end
    end else if (w_push) begin
      w_fill_q[sidx] <= cur_fill + 1'b1;
    end else if (w_pop) begin
      w_fill_q[sidx] <= cur_fill - 1'b1;
      w_head_q[sidx] <= head_inc;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    snd_q  <= snd_d;
    seq_q  <= seq_d;
    ack_q  <= ack_d;
    tail_q <= tail_d;
    hold_q <= hold_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // queue fill stays within the chain
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_fill_q <= QFW'(QUEUE_DEPTH))
    else $error("queue fill beyond depth");

  // no held result while ready for a new request
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !hold_v_q && !tail_v_q)
    else $error("result left over at idle");

  // each delivery count step removes exactly one queue entry
  a_deliv_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dt_q != $past(dt_q)) |-> (q_fill_q == $past(q_fill_q) - 1'b1))
    else $error("delivery without pop");

  // an ack request on the sequencer leaves it idle
  a_seq_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (in_data_i.opcode == OP_ACK) &&
     (node_id_q == SEQUENCER_ID)) |=> (state_q == S_IDLE))
    else $error("sequencer did not ignore ack");
endmodule
